// ===== rtl/core/indexed_list_store_macros.svh =====
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ILST_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define ILST_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the following cycle.
`define ILST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ilst_pkg.sv =====
// Shared constants and types of the indexed list store.
package ilst_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_PUSH   = 3'd0;
  localparam op_t OP_POP    = 3'd1;
  localparam op_t OP_INSERT = 3'd2;
  localparam op_t OP_DELETE = 3'd3;
  localparam op_t OP_SET    = 3'd4;
  localparam op_t OP_GET    = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

endpackage

// ===== rtl/core/ilst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ilst_ram #(
  parameter int WIDTH = ilst_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = ilst_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Top level of the indexed list store: request sequencer around one element RAM.
//
//   Channel  Ports                      Beat contents
//   in       in_tvalid/in_tready        tuser: operation; tdata: position, item_value
//   out      out_tvalid/out_tready      tdata: read_value, status, length
//
// A request that touches no element goes straight to the done state; one that only writes
// one passes through the put state, and a get through the read and get states. An insert
// or delete moves each entry over the single RAM read and write port, in a read state and
// then a write state; an insert ends in the put state. A set that opens a gap zero-fills it
// in the fill state. Reset clears the state, the length and out_tvalid, not the RAM.
// A result waiting on out_tready holds the sequencer in its final state.
`include "indexed_list_store_macros.svh"

module indexed_list_store #(
  parameter int DEPTH      = ilst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ilst_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // position [5:0], item_value [37:6], zero padding [39:38]
  input  logic [ilst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation [2:0]
  input  logic [ilst_pkg::OP_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_value [31:0], status [33:32], length [40:34], zero padding [47:41]
  output logic [ilst_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import ilst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_WR   = 7'b0000100,
    S_FILL = 7'b0001000,
    S_PUT  = 7'b0010000,
    S_GET  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  op_t                    op_r, op_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  status_t                st_r, st_nxt;
  logic [DATA_WIDTH-1:0]  res_r, res_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   acc;
  logic [POS_W-1:0]       in_pos;
  logic [VAL_W-1:0]       in_val;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          pos_inc;
  logic [XW-1:0]          cnt_x;
  logic [EW-1:0]          val_ext;
  logic [EW-1:0]          res_ext;
  logic [LW-1:0]          len_ext;
  logic [AW-1:0]          nb;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign in_pos    = in_tdata[POS_W-1:0];
  assign in_val    = in_tdata[POS_W +: VAL_W];
  assign pos_x     = XW'(in_pos);
  assign pos_inc   = pos_x + XW'(1);
  assign cnt_x     = XW'(count_r);
  assign val_ext   = EW'(in_val);
  assign res_ext   = EW'(res_r);
  assign len_ext   = LW'(count_r);

  // The shared index step: downwards while an insert opens a hole, upwards otherwise.
  assign nb = (op_r == OP_INSERT) ? (idx_r - AW'(1)) : (idx_r + AW'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = val_r;
    ram_raddr      = nb;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          val_nxt   = val_ext[DATA_WIDTH-1:0];
          pos_nxt   = pos_x[AW-1:0];
          st_nxt    = ST_OK;
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_tuser)
            OP_PUSH: begin
              if (cnt_x == DEPTH_X) begin
                st_nxt = ST_FULL;
              end else begin
                idx_nxt   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_PUT;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                st_nxt = ST_RANGE;
              end else if (cnt_x == DEPTH_X) begin
                st_nxt = ST_FULL;
              end else begin
                idx_nxt   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = (pos_x == cnt_x) ? S_PUT : S_RD;
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt   = pos_x[AW-1:0];
                count_nxt = count_r - CW'(1);
                if (pos_inc != cnt_x) begin
                  state_nxt = S_RD;
                end
              end
            end
            OP_SET: begin
              if (pos_x >= DEPTH_X) begin
                st_nxt = ST_RANGE;
              end else if (pos_x < cnt_x) begin
                idx_nxt   = pos_x[AW-1:0];
                state_nxt = S_PUT;
              end else begin
                count_nxt = pos_inc[CW-1:0];
                if (pos_x == cnt_x) begin
                  idx_nxt   = pos_x[AW-1:0];
                  state_nxt = S_PUT;
                end else begin
                  idx_nxt   = count_r[AW-1:0];
                  state_nxt = S_FILL;
                end
              end
            end
            OP_GET: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt   = pos_x[AW-1:0];
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (op_r == OP_GET) begin
          ram_raddr = idx_r;
          state_nxt = S_GET;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = nb;
        if (op_r == OP_INSERT) begin
          state_nxt = (nb == pos_r) ? S_PUT : S_RD;
        end else begin
          state_nxt = (nb == count_r[AW-1:0]) ? S_DONE : S_RD;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_nxt   = nb;
        if (nb == pos_r) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_GET: begin
        res_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = OUT_TDATA_W'({len_ext[LEN_W-1:0], st_r, res_ext[VAL_W-1:0]});
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    st_r       <= st_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  ilst_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ILST_ASSERT_HOLDS(a_count_bound, cnt_x <= DEPTH_X, "Length exceeds the capacity.")
  `ILST_ASSERT_IMPLIES(a_write_below_length, ram_we, XW'(ram_waddr) < cnt_x, "Write beyond the length.")
  `ILST_ASSERT_NEXT(a_count_only_on_accept, !acc, $stable(count_r), "Length moved without a request.")
  `ILST_ASSERT_NEXT(a_busy_after_accept, acc, !in_tready, "Ready straight after a request.")
  `ILST_ASSERT_IMPLIES(a_result_from_done, $rose(out_tvalid_r), $past(state_r == S_DONE), "Result outside completion.")

endmodule
